>>> hw/rtl/plas_pkg.sv
`default_nettype none

package plas_pkg;

	// register values are 16 bits at most
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PRECHARGE_MS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LEN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_MS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_DELAY_MS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENABLE   = 3'd4;

	// reset values of the registers
	localparam logic [CFG_DATA_W-1:0] RST_PRECHARGE_MS  = 16'd1000;
	localparam logic [CFG_DATA_W-1:0] RST_PULSE_LEN     = 16'd50;
	localparam logic [CFG_DATA_W-1:0] RST_OVERLAP_MS    = 16'd250;
	localparam logic [CFG_DATA_W-1:0] RST_AUTO_DELAY_MS = 16'd3000;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] precharge_ms;
		logic [CFG_DATA_W-1:0] pulse_len;
		logic [CFG_DATA_W-1:0] overlap_ms;
		logic [CFG_DATA_W-1:0] arm_delay;
		logic                  auto_arm_enable;
	} cfg_t;

	typedef enum logic [1:0] {
		MODE_TICK    = 2'd0,
		MODE_ARM     = 2'd1,
		MODE_PRE_ON  = 2'd2,
		MODE_PRE_OFF = 2'd3
	} mode_t;

	typedef enum logic [4:0] {
		PH_OFF     = 5'b00001,
		PH_PRE     = 5'b00010,
		PH_PULSE   = 5'b00100,
		PH_OVERLAP = 5'b01000,
		PH_ON      = 5'b10000
	} phase_t;

	// phase codes as seen on the result
	localparam logic [2:0] PHC_OFF     = 3'd0;
	localparam logic [2:0] PHC_PRE     = 3'd1;
	localparam logic [2:0] PHC_PULSE   = 3'd2;
	localparam logic [2:0] PHC_OVERLAP = 3'd3;
	localparam logic [2:0] PHC_ON      = 3'd4;

	typedef enum logic [2:0] {
		EV_NONE         = 3'd0,
		EV_ARM_STARTED  = 3'd1,
		EV_ARM_BUSY     = 3'd2,
		EV_ARM_KILL     = 3'd3,
		EV_ABORT_KILL   = 3'd4,
		EV_LATCHED      = 3'd5,
		EV_KILL_ASSERT  = 3'd6,
		EV_KILL_RELEASE = 3'd7
	} ev_t;

	typedef struct packed {
		logic       precharge;
		logic       latch_set;
		logic [2:0] phase;
		ev_t        ev;
	} res_t;

	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] c;
		unique case (ph)
			PH_OFF:     c = PHC_OFF;
			PH_PRE:     c = PHC_PRE;
			PH_PULSE:   c = PHC_PULSE;
			PH_OVERLAP: c = PHC_OVERLAP;
			PH_ON:      c = PHC_ON;
			default:    c = PHC_OFF;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/plas_cfg_regs.sv
`default_nettype none

module plas_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [plas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [plas_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	output plas_pkg::cfg_t                       cfg
);
	import plas_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.precharge_ms    <= RST_PRECHARGE_MS;
			cfg_q.pulse_len       <= RST_PULSE_LEN;
			cfg_q.overlap_ms      <= RST_OVERLAP_MS;
			cfg_q.arm_delay       <= RST_AUTO_DELAY_MS;
			cfg_q.auto_arm_enable <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_PRECHARGE_MS:  cfg_q.precharge_ms    <= cfg_wr_data;
				CFG_PULSE_LEN:     cfg_q.pulse_len       <= cfg_wr_data;
				CFG_OVERLAP_MS:    cfg_q.overlap_ms      <= cfg_wr_data;
				CFG_AUTO_DELAY_MS: cfg_q.arm_delay       <= cfg_wr_data;
				CFG_AUTO_ENABLE:   cfg_q.auto_arm_enable <= cfg_wr_data[0];
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> hw/rtl/plas_core.sv
`default_nettype none

module plas_core #(
	parameter int unsigned TIMER_WIDTH = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step_en,
	input  wire plas_pkg::mode_t mode,
	input  wire logic     kill,
	input  wire plas_pkg::cfg_t  cfg,
	output plas_pkg::res_t  res
);
	import plas_pkg::*;

	localparam int unsigned CMP_W = (TIMER_WIDTH > CFG_DATA_W) ? TIMER_WIDTH : CFG_DATA_W;

	phase_t                 phase_q, ph_n;
	logic [TIMER_WIDTH-1:0] elapsed_q, el_n;
	logic [TIMER_WIDTH-1:0] uptime_q, up_n;
	logic                   kill_seen_q;
	logic                   auto_wait_q, aw_n;
	logic                   pre_q, pre_n;
	logic                   latch_q, lat_n;
	ev_t                    kev, ev, ev_out;

	function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	always_comb begin
		ph_n  = phase_q;
		el_n  = elapsed_q;
		up_n  = uptime_q;
		aw_n  = auto_wait_q;
		pre_n = pre_q;
		lat_n = latch_q;
		kev   = EV_NONE;
		ev    = EV_NONE;

		// kill edge handling comes first
		if (kill != kill_seen_q) begin
			if (kill) begin
				if (phase_q == PH_PRE || phase_q == PH_PULSE || phase_q == PH_OVERLAP) begin
					pre_n = 1'b0;
					lat_n = 1'b0;
					ph_n  = PH_OFF;
					el_n  = '0;
					kev   = EV_ABORT_KILL;
				end else begin
					kev = EV_KILL_ASSERT;
				end
			end else if (phase_q == PH_ON) begin
				kev = EV_KILL_RELEASE;
			end
		end

		unique case (mode)
			MODE_TICK: begin
				up_n = sat_inc(uptime_q);
				el_n = sat_inc(el_n);
				unique case (ph_n)
					PH_PRE: begin
						if (kill) begin
							pre_n = 1'b0;
							lat_n = 1'b0;
							ph_n  = PH_OFF;
							el_n  = '0;
							ev    = EV_ABORT_KILL;
						end else if (CMP_W'(el_n) >= CMP_W'(cfg.precharge_ms)) begin
							lat_n = 1'b1;
							ph_n  = PH_PULSE;
							el_n  = '0;
						end
					end
					PH_PULSE: begin
						if (CMP_W'(el_n) >= CMP_W'(cfg.pulse_len)) begin
							lat_n = 1'b0;
							ph_n  = PH_OVERLAP;
							el_n  = '0;
						end
					end
					PH_OVERLAP: begin
						if (CMP_W'(el_n) >= CMP_W'(cfg.overlap_ms)) begin
							pre_n = 1'b0;
							ph_n  = PH_ON;
							el_n  = '0;
							ev    = EV_LATCHED;
						end
					end
					default: ;
				endcase
				// one-shot auto arm, phase off and kill clear so it always starts
				if (cfg.auto_arm_enable && auto_wait_q && !kill && ph_n == PH_OFF &&
				    CMP_W'(up_n) >= CMP_W'(cfg.arm_delay)) begin
					aw_n  = 1'b0;
					pre_n = 1'b1;
					ph_n  = PH_PRE;
					el_n  = '0;
					ev    = EV_ARM_STARTED;
				end
			end
			MODE_ARM: begin
				aw_n = 1'b0;
				if (ph_n != PH_OFF) begin
					ev = EV_ARM_BUSY;
				end else if (kill) begin
					ev = EV_ARM_KILL;
				end else begin
					pre_n = 1'b1;
					ph_n  = PH_PRE;
					el_n  = '0;
					ev    = EV_ARM_STARTED;
				end
			end
			MODE_PRE_ON:  pre_n = 1'b1;
			MODE_PRE_OFF: pre_n = 1'b0;
			default: ;
		endcase

		// an abort always wins, otherwise the item's own event replaces a kill edge
		ev_out = (kev == EV_ABORT_KILL || ev == EV_NONE) ? kev : ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OFF;
			elapsed_q   <= '0;
			uptime_q    <= '0;
			kill_seen_q <= 1'b0;
			auto_wait_q <= 1'b1;
			pre_q       <= 1'b0;
			latch_q     <= 1'b0;
		end else if (step_en) begin
			phase_q     <= ph_n;
			elapsed_q   <= el_n;
			uptime_q    <= up_n;
			kill_seen_q <= kill;
			auto_wait_q <= aw_n;
			pre_q       <= pre_n;
			latch_q     <= lat_n;
		end
	end

	assign res.precharge = pre_n;
	assign res.latch_set = lat_n;
	assign res.phase     = phase_code(ph_n);
	assign res.ev        = ev_out;

`ifndef ASSERT_OFF
	// latch drive is high exactly during the latch pulse
	a_latch_phase: assert property (@(posedge clk) disable iff (!arst_n)
		latch_q == (phase_q == PH_PULSE))
		else $error("latch drive out of step with phase");

	// a running sequence never coexists with a seen kill
	a_no_kill_run: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PRE || phase_q == PH_PULSE || phase_q == PH_OVERLAP) |-> !kill_seen_q)
		else $error("sequence running with kill asserted");

	// auto arm is one-shot: once cleared it never comes back
	a_auto_once: assert property (@(posedge clk) disable iff (!arst_n)
		!auto_wait_q |=> !auto_wait_q)
		else $error("auto arm re-armed");

	// uptime only advances on a tick
	a_uptime_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(uptime_q != $past(uptime_q)) |-> ($past(step_en) && $past(mode) == MODE_TICK))
		else $error("uptime moved without a tick");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/precharge_latch_arm_sequencer.sv
`default_nettype none

// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+------------------------------------------------
// in       | input     | in_valid/in_stall  | mode[1:0], kill_level
// out      | output    | out_valid/out_stall| precharge_drive, latch_set_drive, phase_now[2:0],
//          |           |                    | event_res[2:0]
// cfg      | input     | cfg_wr_en          | cfg_index[2:0], cfg_wr_data[15:0]
//
// one transaction in, one transaction out; a new input transaction can be taken
// every cycle while the result register is not stalled, through the input register,
// then the state update in plas_core, which is the loop that sets the rate, and the result register
// arst_n puts the core in the off phase with both drives low, auto arm pending,
// and the registers at their default timings
// out_stall only holds the result register; the input register keeps taking
// transactions while it is empty or drains into the result register
module precharge_latch_arm_sequencer #(
	parameter int unsigned TIMER_WIDTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input channel
	input  wire logic                            in_valid,
	output      logic                            in_stall,
	input  wire logic [1:0]                      mode,
	input  wire logic                            kill_level,
	// result channel
	output      logic                            out_valid,
	input  wire logic                            out_stall,
	output      logic                            precharge_drive,
	output      logic                            latch_set_drive,
	output      logic [2:0]                      phase_now,
	output      logic [2:0]                      event_res,
	// configuration write port
	input  wire logic                            cfg_wr_en,
	input  wire logic [plas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [plas_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
	import plas_pkg::*;

	cfg_t       cfg;
	res_t       res;
	res_t       res_q;
	logic       valid_s1;
	logic [1:0] mode_s1;
	logic       kill_s1;
	logic       out_valid_q;
	logic       advance;
	logic       step_en;

	// result register is empty or drains this cycle
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign step_en  = valid_s1 && advance;

	plas_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.cfg         (cfg)
	);

	// input register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1 <= mode;
			kill_s1 <= kill_level;
		end
	end

	// state update and next result, one transaction per cycle while the result register is not stalled
	plas_core #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.mode    (mode_t'(mode_s1)),
		.kill    (kill_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign precharge_drive = res_q.precharge;
	assign latch_set_drive = res_q.latch_set;
	assign phase_now       = res_q.phase;
	assign event_res       = res_q.ev;

endmodule

`default_nettype wire

>>> bench/precharge_latch_arm_sequencer_tb.sv
`timescale 1ns / 1ps

module precharge_latch_arm_sequencer_tb;

	import plas_pkg::*;

	localparam int unsigned TIMER_W         = 16;
	// longest quiet stretch of a correct run is the long hold-off, well below this
	localparam int unsigned WATCHDOG_LIMIT  = 1000;
	localparam int unsigned HOLD_OFF_CYCLES = 80;

	// clock, reset and block ports; the ones driven here are known from time zero
	logic                  clk             = 1'b0;
	logic                  arst_n          = 1'b0;
	logic                  in_valid        = 1'b0;
	logic                  in_stall;
	logic [1:0]            mode            = MODE_TICK;
	logic                  kill_level      = 1'b0;
	logic                  out_valid;
	logic                  out_stall       = 1'b0;
	logic                  precharge_drive;
	logic                  latch_set_drive;
	logic [2:0]            phase_now;
	logic [2:0]            event_res;
	logic                  cfg_wr_en       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index       = CFG_PRECHARGE_MS;
	logic [CFG_DATA_W-1:0] cfg_wr_data     = '0;

	// idling controls shared by the sender, the stall process and the tests
	bit send_gaps        = 1'b1;
	bit stall_gaps       = 1'b1;
	bit hold_off_request = 1'b0;

	// expected results in acceptance order, and the failure count
	res_t        pending_results[$];
	int unsigned mismatch_count = 0;

	// predicted sequencer state and register copy
	cfg_t               model_cfg;
	logic [2:0]         seq_phase;
	logic [TIMER_W-1:0] phase_ticks;
	logic [TIMER_W-1:0] uptime_count;
	logic               seen_kill;
	logic               auto_pending;
	logic               drive_pre;
	logic               drive_latch;

	precharge_latch_arm_sequencer #(
		.TIMER_WIDTH(TIMER_W)
	) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.kill_level      (kill_level),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.precharge_drive (precharge_drive),
		.latch_set_drive (latch_set_drive),
		.phase_now       (phase_now),
		.event_res       (event_res),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wr_data     (cfg_wr_data)
	);

	always #1 clk = ~clk;

	// both drives low, back to off
	function automatic void drop_sequence();
		drive_pre   = 1'b0;
		drive_latch = 1'b0;
		seq_phase   = PHC_OFF;
		phase_ticks = '0;
	endfunction

	// shared by the arm command and the automatic arm
	function automatic ev_t start_arm();
		if (seq_phase != PHC_OFF)
			return EV_ARM_BUSY;
		if (seen_kill)
			return EV_ARM_KILL;
		drive_pre   = 1'b1;
		seq_phase   = PHC_PRE;
		phase_ticks = '0;
		return EV_ARM_STARTED;
	endfunction

	// steps the predicted sequencer by one transaction and returns its result
	function automatic res_t advance_sequencer(input mode_t m, input logic k);
		ev_t  kill_ev;
		ev_t  item_ev;
		res_t r;
		kill_ev = EV_NONE;
		item_ev = EV_NONE;
		// kill is sampled before the transaction itself is acted on
		if (k != seen_kill) begin
			seen_kill = k;
			if (k) begin
				if (seq_phase == PHC_PRE || seq_phase == PHC_PULSE ||
					seq_phase == PHC_OVERLAP) begin
					drop_sequence();
					kill_ev = EV_ABORT_KILL;
				end else begin
					kill_ev = EV_KILL_ASSERT;
				end
			end else if (seq_phase == PHC_ON) begin
				kill_ev = EV_KILL_RELEASE;
			end
		end
		case (m)
			MODE_TICK: begin
				// both timers saturate
				if (uptime_count != '1)
					uptime_count = uptime_count + 1'b1;
				if (phase_ticks != '1)
					phase_ticks = phase_ticks + 1'b1;
				if (seq_phase == PHC_PRE && seen_kill) begin
					drop_sequence();
					item_ev = EV_ABORT_KILL;
				end else begin
					case (seq_phase)
						PHC_PRE: if (phase_ticks >= model_cfg.precharge_ms) begin
							drive_latch = 1'b1;
							seq_phase   = PHC_PULSE;
							phase_ticks = '0;
						end
						PHC_PULSE: if (phase_ticks >= model_cfg.pulse_len) begin
							drive_latch = 1'b0;
							seq_phase   = PHC_OVERLAP;
							phase_ticks = '0;
						end
						PHC_OVERLAP: if (phase_ticks >= model_cfg.overlap_ms) begin
							drive_pre   = 1'b0;
							seq_phase   = PHC_ON;
							phase_ticks = '0;
							item_ev     = EV_LATCHED;
						end
						default: ;
					endcase
					// one-shot automatic arm, only looked at on ticks
					if (model_cfg.auto_arm_enable && auto_pending && !seen_kill &&
						uptime_count >= model_cfg.arm_delay && seq_phase == PHC_OFF) begin
						auto_pending = 1'b0;
						item_ev      = start_arm();
					end
				end
			end
			MODE_ARM: begin
				auto_pending = 1'b0;
				item_ev      = start_arm();
			end
			MODE_PRE_ON:  drive_pre = 1'b1;
			MODE_PRE_OFF: drive_pre = 1'b0;
			default: ;
		endcase
		// an abort always wins, otherwise the item's own event replaces a kill edge event
		if (kill_ev == EV_ABORT_KILL || item_ev == EV_NONE)
			item_ev = kill_ev;
		r.precharge = drive_pre;
		r.latch_set = drive_latch;
		r.phase     = seq_phase;
		r.ev        = item_ev;
		return r;
	endfunction

	// one input transaction: optional gap, then hold until accepted
	task automatic send_transaction(input mode_t m, input logic k);
		int unsigned gap;
		gap = send_gaps ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		kill_level <= k;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(advance_sequencer(m, k));
	endtask

	// stop offering and wait until every result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_PRECHARGE_MS:  model_cfg.precharge_ms    = value;
			CFG_PULSE_LEN:     model_cfg.pulse_len       = value;
			CFG_OVERLAP_MS:    model_cfg.overlap_ms      = value;
			CFG_AUTO_DELAY_MS: model_cfg.arm_delay       = value;
			CFG_AUTO_ENABLE:   model_cfg.auto_arm_enable = value[0];
			default: ;
		endcase
	endtask

	task automatic set_timings(input logic [CFG_DATA_W-1:0] pre_ms,
		input logic [CFG_DATA_W-1:0] pulse_ms, input logic [CFG_DATA_W-1:0] ovl_ms);
		drain_results();
		write_register(CFG_PRECHARGE_MS, pre_ms);
		write_register(CFG_PULSE_LEN, pulse_ms);
		write_register(CFG_OVERLAP_MS, ovl_ms);
	endtask

	// mostly ticks and arms with a slowly wandering kill level
	task automatic send_random_transaction();
		int unsigned pick;
		mode_t       m;
		logic        k;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			m = MODE_TICK;
		else if (pick < 82)
			m = MODE_ARM;
		else if (pick < 91)
			m = MODE_PRE_ON;
		else
			m = MODE_PRE_OFF;
		k = seen_kill;
		if (k) begin
			if ($urandom_range(0, 3) == 0)
				k = 1'b0;
		end else if ($urandom_range(0, 39) == 0) begin
			k = 1'b1;
		end
		// latched on is a dead end, so kill the sequence on the tick that would finish overlap
		if (seq_phase == PHC_OVERLAP && m == MODE_TICK &&
			{1'b0, phase_ticks} + 17'd1 >= {1'b0, model_cfg.overlap_ms})
			k = 1'b1;
		send_transaction(m, k);
	endtask

	task automatic run_random_phase(input logic [CFG_DATA_W-1:0] pre_ms,
		input logic [CFG_DATA_W-1:0] pulse_ms, input logic [CFG_DATA_W-1:0] ovl_ms,
		input int unsigned count, input bit gaps);
		set_timings(pre_ms, pulse_ms, ovl_ms);
		// the automatic arm is spent by now, the write must still not disturb anything
		write_register(CFG_AUTO_ENABLE, CFG_DATA_W'($urandom_range(0, 1)));
		send_gaps  = gaps;
		stall_gaps = gaps;
		repeat (count) send_random_transaction();
		send_gaps  = 1'b1;
		stall_gaps = 1'b1;
	endtask

	// register defaults: ticks well short of the auto arm delay, manual drive, kill edges in off
	task automatic test_reset_defaults();
		send_transaction(MODE_TICK, 1'b0);
		send_transaction(MODE_PRE_ON, 1'b1);
		send_transaction(MODE_TICK, 1'b1);
		send_transaction(MODE_PRE_OFF, 1'b0);
	endtask

	// the automatic arm: held off by enable and by kill, fires once uptime reaches the delay
	task automatic test_auto_arm_once();
		drain_results();
		write_register(CFG_AUTO_ENABLE, 16'd0);
		write_register(CFG_AUTO_DELAY_MS, 16'd1);
		set_timings(16'd2, 16'd0, 16'd2);
		send_transaction(MODE_TICK, 1'b0);
		drain_results();
		write_register(CFG_AUTO_ENABLE, 16'd1);
		send_transaction(MODE_TICK, 1'b1);
		drain_results();
		write_register(CFG_AUTO_ENABLE, 16'd0);
		// kill released while the automatic arm is switched off
		send_transaction(MODE_TICK, 1'b0);
		drain_results();
		// uptime is already past the delay, so the first enabled tick fires
		write_register(CFG_AUTO_ENABLE, 16'd1);
		send_transaction(MODE_TICK, 1'b0);
		send_transaction(MODE_PRE_OFF, 1'b0);
		send_transaction(MODE_TICK, 1'b0);
		send_transaction(MODE_TICK, 1'b0);
		// zero pulse length still takes a tick
		send_transaction(MODE_TICK, 1'b0);
		send_transaction(MODE_TICK, 1'b1);
		// back in off with everything met, but no second automatic arm
		send_transaction(MODE_TICK, 1'b0);
	endtask

	// arm commands: blocked by kill, busy, aborts in each running phase
	task automatic test_arm_and_abort();
		set_timings(16'd0, 16'd1, 16'd3);
		send_transaction(MODE_ARM, 1'b1);
		send_transaction(MODE_ARM, 1'b0);
		send_transaction(MODE_ARM, 1'b0);
		send_transaction(MODE_TICK, 1'b0);
		send_transaction(MODE_PRE_OFF, 1'b0);
		send_transaction(MODE_TICK, 1'b0);
		// abort in overlap, then the manual command drives precharge in off
		send_transaction(MODE_PRE_ON, 1'b1);
		send_transaction(MODE_PRE_OFF, 1'b0);
		send_transaction(MODE_ARM, 1'b0);
		// abort beats the blocked arm of the same transaction
		send_transaction(MODE_ARM, 1'b1);
		send_transaction(MODE_TICK, 1'b0);
		send_transaction(MODE_ARM, 1'b0);
		send_transaction(MODE_TICK, 1'b0);
		send_transaction(MODE_TICK, 1'b1);
	endtask

	task automatic test_random_sequences();
		run_random_phase(16'd0, 16'd0, 16'd0, 180, 1'b1);
		run_random_phase(16'd1, 16'd1, 16'd1, 120, 1'b0);
		run_random_phase(CFG_DATA_W'($urandom_range(0, 12)), CFG_DATA_W'($urandom_range(0, 12)),
			CFG_DATA_W'($urandom_range(0, 12)), 180, 1'b1);
		run_random_phase(CFG_DATA_W'($urandom_range(0, 6)), CFG_DATA_W'($urandom_range(0, 6)),
			CFG_DATA_W'($urandom_range(0, 6)), 150, 1'b1);
		// largest timings: sequences only ever end by kill
		run_random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 60, 1'b1);
		run_random_phase(16'd2, 16'hFFFF, 16'd0, 60, 1'b1);
		run_random_phase(CFG_DATA_W'($urandom_range(0, 20)), CFG_DATA_W'($urandom_range(0, 20)),
			CFG_DATA_W'($urandom_range(0, 20)), 90, 1'b0);
	endtask

	// full sequence into latched on, then kill edges and commands there
	task automatic test_latched_on();
		set_timings(16'd1, 16'd0, 16'd0);
		// any leftover sequence is aborted here, or kill was already high in off
		send_transaction(MODE_PRE_OFF, 1'b1);
		send_transaction(MODE_ARM, 1'b0);
		send_transaction(MODE_TICK, 1'b0);
		send_transaction(MODE_TICK, 1'b0);
		send_transaction(MODE_TICK, 1'b0);
		send_transaction(MODE_ARM, 1'b0);
		send_transaction(MODE_TICK, 1'b1);
		// busy arm replaces the kill release event
		send_transaction(MODE_ARM, 1'b0);
		send_transaction(MODE_PRE_ON, 1'b1);
		send_transaction(MODE_TICK, 1'b0);
	endtask

	// long receiver hold-off while transactions first come back to back, then with gaps
	task automatic test_backpressure();
		hold_off_request = 1'b1;
		send_gaps        = 1'b0;
		repeat (40) send_random_transaction();
		send_gaps = 1'b1;
		repeat (40) send_random_transaction();
	endtask

	// receiver side: a random stall before each result, or the long hold-off on request
	initial begin : result_stall
		int unsigned hold;
		@(posedge clk);
		forever begin
			if (hold_off_request) begin
				hold             = HOLD_OFF_CYCLES;
				hold_off_request = 1'b0;
			end else begin
				hold = stall_gaps ? $urandom_range(0, 6) : 0;
			end
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// every accepted result against the oldest expectation
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing expected");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (precharge_drive !== want.precharge) begin
					$error("precharge_drive expected %0d actual %0d", want.precharge,
						precharge_drive);
					mismatch_count++;
				end
				if (latch_set_drive !== want.latch_set) begin
					$error("latch_set_drive expected %0d actual %0d", want.latch_set,
						latch_set_drive);
					mismatch_count++;
				end
				if (phase_now !== want.phase) begin
					$error("phase_now expected %0d actual %0d", want.phase, phase_now);
					mismatch_count++;
				end
				if (event_res !== want.ev) begin
					$error("event_res expected %0d actual %0d", want.ev, event_res);
					mismatch_count++;
				end
			end
		end
	end

	// ends the run when nothing is accepted on either side for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		// predicted state at reset
		model_cfg.precharge_ms    = RST_PRECHARGE_MS;
		model_cfg.pulse_len       = RST_PULSE_LEN;
		model_cfg.overlap_ms      = RST_OVERLAP_MS;
		model_cfg.arm_delay       = RST_AUTO_DELAY_MS;
		model_cfg.auto_arm_enable = 1'b1;
		seq_phase    = PHC_OFF;
		phase_ticks  = '0;
		uptime_count = '0;
		seen_kill    = 1'b0;
		auto_pending = 1'b1;
		drive_pre    = 1'b0;
		drive_latch  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_auto_arm_once();
		test_arm_and_abort();
		test_random_sequences();
		test_latched_on();
		test_backpressure();
		// wait out the pipeline so a stray extra result is still caught
		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
